// ----- sv/line_substring_filter_top_assert.svh -----
// assertion macros for the line substring filter
`ifndef LINE_SUBSTRING_FILTER_TOP_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_TOP_ASSERT_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define LSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition that must never be seen out of reset
`define LSF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LSF_ASSERT(label, prop, msg)
`define LSF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ----- sv/lsf_pkg.sv -----
// constants and helpers for the line substring filter
package lsf_pkg;

	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned CFG_INDEX_W   = 3;
	localparam int unsigned LINE_NUMBER_W = 32;
	localparam int unsigned PAT_REG_BYTES = 16;
	localparam int unsigned PAT_LEN_W     = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FOLD_CASE      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MATCH   = 3'd4;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;
	localparam logic [7:0] UPPER_A      = 8'h41;
	localparam logic [7:0] UPPER_Z      = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [LINE_NUMBER_W-1:0] COUNT_MAX = '1;

	// ascii a-z folding when enabled
	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && (c >= UPPER_A) && (c <= UPPER_Z)) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ----- sv/line_substring_filter_top.sv -----
// line substring filter: per-line fixed pattern search over a byte stream
// Scans a text stream at one byte per clock and, for every line, reports
// whether it contains the configured pattern (up to 16 bytes, optional ascii
// case folding, optional inversion). A newline byte, or end_of_input while a
// line is open, produces one result with the selection, the saturating
// 1-based line number and a sticky any-selected flag. An item is taken into
// an input stage and scanned there by a single shift-and step
// against all pattern bytes in parallel; its result is then written to
// the output register. One item per cycle is sustained, set by
// the shift-and update of the partial match vector; the input only stalls
// while a result waits in the output register and the staged item has another
// result to give. Configuration writes take effect for bytes scanned after
// them and must be made while no item is in flight.
module line_substring_filter_top #(
	parameter int unsigned PATTERN_BYTES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [lsf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            data_byte,
	input  logic                                  end_of_input,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  line_selected,
	output logic [lsf_pkg::LINE_NUMBER_W-1:0]     line_number,
	output logic                                  any_selected
);

	`include "line_substring_filter_top_assert.svh"

	localparam int unsigned PAD_BYTES =
		(PATTERN_BYTES > lsf_pkg::PAT_REG_BYTES) ? PATTERN_BYTES : lsf_pkg::PAT_REG_BYTES;
	localparam int unsigned IDX_W = 7;

	// configuration
	logic [lsf_pkg::CFG_DATA_W-1:0] pattern_lo_q;
	logic [lsf_pkg::CFG_DATA_W-1:0] pattern_hi_q;
	logic [lsf_pkg::PAT_LEN_W-1:0]  pattern_length_q;
	logic                           fold_case_q;
	logic                           invert_match_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// line state
	logic [PATTERN_BYTES-1:0]          ph_q;
	logic                              hit_q;
	logic                              cut_q;
	logic                              open_q;
	logic [lsf_pkg::LINE_NUMBER_W-1:0] count_q;
	logic                              sticky_q;

	// result register
	logic                              out_valid_q;
	logic                              sel_q;
	logic [lsf_pkg::LINE_NUMBER_W-1:0] number_q;
	logic                              any_q;

	logic [8*PAD_BYTES-1:0]   pat_pad;
	logic [PATTERN_BYTES-1:0] zero_at;
	logic                     zero_seen;
	logic [PATTERN_BYTES-1:0] lmask;
	logic [PATTERN_BYTES-1:0] top_bit;
	logic [PATTERN_BYTES-1:0] eq;
	logic [PATTERN_BYTES-1:0] ph_scan;
	logic [7:0]               fc;
	logic                     scan_en;
	logic                     scan_hit;
	logic                     emit_s1;
	logic                     advance;
	logic                     line_hit_final;
	logic                     sel_next;
	logic [lsf_pkg::LINE_NUMBER_W-1:0] count_next;

	assign pat_pad = (8*PAD_BYTES)'({pattern_hi_q, pattern_lo_q});

	// live pattern positions: below the length and before any zero byte
	always_comb begin
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			zero_at[i] = (pat_pad[8*i +: 8] == lsf_pkg::ZERO_BYTE);
		end
		zero_seen = 1'b0;
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			zero_seen = zero_seen || zero_at[i];
			lmask[i] = (IDX_W'(i) < IDX_W'(pattern_length_q)) && !zero_seen;
		end
		top_bit = lmask & ~(lmask >> 1);
	end

	always_comb begin
		fc = lsf_pkg::fold_byte(byte_s1, fold_case_q);
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			eq[i] = (lsf_pkg::fold_byte(pat_pad[8*i +: 8], fold_case_q) == fc);
		end
		ph_scan  = ((ph_q << 1) | PATTERN_BYTES'(1)) & eq & lmask;
		scan_en  = !eoi_s1 && (byte_s1 != lsf_pkg::ZERO_BYTE) && !cut_q;
		scan_hit = scan_en && ((ph_scan & top_bit) != '0);
	end

	assign emit_s1 = valid_s1 && (eoi_s1 ? open_q : (byte_s1 == lsf_pkg::NEWLINE_BYTE));
	assign advance = !emit_s1 || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign line_hit_final = hit_q || scan_hit || (lmask == '0);
	assign sel_next = line_hit_final ^ invert_match_q;
	assign count_next = (count_q == lsf_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_lo_q     <= '0;
			pattern_hi_q     <= '0;
			pattern_length_q <= '0;
			fold_case_q      <= 1'b0;
			invert_match_q   <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				lsf_pkg::REG_PATTERN_LO:     pattern_lo_q     <= cfg_data;
				lsf_pkg::REG_PATTERN_HI:     pattern_hi_q     <= cfg_data;
				lsf_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[lsf_pkg::PAT_LEN_W-1:0];
				lsf_pkg::REG_FOLD_CASE:      fold_case_q      <= cfg_data[0];
				lsf_pkg::REG_INVERT_MATCH:   invert_match_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= '0;
			hit_q    <= 1'b0;
			cut_q    <= 1'b0;
			open_q   <= 1'b0;
			count_q  <= '0;
			sticky_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (emit_s1) begin
				ph_q    <= '0;
				hit_q   <= 1'b0;
				cut_q   <= 1'b0;
				open_q  <= 1'b0;
				count_q <= count_next;
				if (sel_next) begin
					sticky_q <= 1'b1;
				end
			end else if (!eoi_s1) begin
				open_q <= 1'b1;
				if (byte_s1 == lsf_pkg::ZERO_BYTE) begin
					cut_q <= 1'b1;
				end
				if (scan_en) begin
					ph_q <= ph_scan;
				end
				if (scan_hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit_s1) begin
			sel_q    <= sel_next;
			number_q <= count_next;
			any_q    <= sticky_q || sel_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_selected = sel_q;
	assign line_number   = number_q;
	assign any_selected  = any_q;

	`LSF_ASSERT(a_number_nonzero, out_valid_q |-> (number_q != '0), "result with line number zero")
	`LSF_ASSERT(a_sel_sets_any, (out_valid_q && sel_q) |-> any_q, "selected line without any flag")
	`LSF_ASSERT_NEVER(a_sticky_holds, $fell(sticky_q), "any-selected flag cleared")
	`LSF_ASSERT(a_cut_in_line, cut_q |-> open_q, "cut flag outside an open line")
	`LSF_ASSERT_NEVER(a_count_back, count_q < $past(count_q), "line count went backwards")

endmodule

// ----- test/line_substring_filter_top_tb.sv -----
// testbench for the line substring filter: random byte streams checked against a line predictor
`timescale 1ns / 1ps

module line_substring_filter_top_tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES   = 55;
	localparam int HOLD_AT_LINE  = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;

	typedef struct packed {
		logic [7:0] value;
		logic       stop;
	} text_item_t;

	typedef struct packed {
		logic        selected;
		logic [31:0] number;
		logic        any;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic line_selected;
	logic [lsf_pkg::LINE_NUMBER_W-1:0] line_number;
	logic any_selected;

	line_substring_filter_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_input  (end_of_input),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_selected (line_selected),
		.line_number   (line_number),
		.any_selected  (any_selected)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register copies
	logic [63:0] cfg_pat_lo = '0;
	logic [63:0] cfg_pat_hi = '0;
	logic [4:0]  cfg_pat_len = '0;
	logic        cfg_fold = 1'b0;
	logic        cfg_invert = 1'b0;

	// line tracking state
	logic [15:0] partial_run = '0;
	logic        hit_seen = 1'b0;
	logic        cut_seen = 1'b0;
	logic        open_line = 1'b0;
	logic [31:0] lines_done = '0;
	logic        any_so_far = 1'b0;

	text_item_t   pending_text[$];
	line_result_t due_lines[$];
	text_item_t   next_text;
	line_result_t want;

	int  bytes_queued = 0;
	int  bytes_taken = 0;
	int  lines_checked = 0;
	int  settings_used = 0;
	int  errors = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  calm = 1'b0;

	function automatic logic [7:0] pat_byte_at(input int i);
		if (i < 8) begin
			return cfg_pat_lo[8*i +: 8];
		end else if (i < 16) begin
			return cfg_pat_hi[8*(i-8) +: 8];
		end
		return lsf_pkg::ZERO_BYTE;
	endfunction

	// pattern stops at its first zero byte, length clamps at the register size
	function automatic int active_length();
		int n;
		int k;
		n = cfg_pat_len;
		if (n > lsf_pkg::PAT_REG_BYTES) begin
			n = lsf_pkg::PAT_REG_BYTES;
		end
		k = n;
		for (int i = n - 1; i >= 0; i--) begin
			if (pat_byte_at(i) == lsf_pkg::ZERO_BYTE) begin
				k = i;
			end
		end
		return k;
	endfunction

	function automatic logic [7:0] folded(input logic [7:0] c);
		if (cfg_fold && c >= lsf_pkg::UPPER_A && c <= lsf_pkg::UPPER_Z) begin
			return c + lsf_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	task automatic scan_text_byte(input logic [7:0] c);
		int len;
		logic [15:0] eq;
		logic [15:0] lmask;
		len = active_length();
		if (len == 0) begin
			partial_run = '0;
		end else begin
			eq = '0;
			for (int i = 0; i < len; i++) begin
				if (folded(pat_byte_at(i)) == folded(c)) begin
					eq[i] = 1'b1;
				end
			end
			lmask = (len >= 16) ? 16'hFFFF : ((16'd1 << len) - 16'd1);
			partial_run = ((partial_run << 1) | 16'd1) & eq & lmask;
			if (partial_run[len-1]) begin
				hit_seen = 1'b1;
			end
		end
	endtask

	task automatic close_line();
		line_result_t r;
		logic hit;
		hit = hit_seen || (active_length() == 0);
		r.selected = hit ^ cfg_invert;
		if (lines_done != lsf_pkg::COUNT_MAX) begin
			lines_done = lines_done + 1;
		end
		if (r.selected) begin
			any_so_far = 1'b1;
		end
		r.number = lines_done;
		r.any = any_so_far;
		due_lines.push_back(r);
		partial_run = '0;
		hit_seen = 1'b0;
		cut_seen = 1'b0;
		open_line = 1'b0;
	endtask

	task automatic track_byte(input logic [7:0] c, input logic stop);
		if (stop) begin
			if (open_line) begin
				close_line();
			end
		end else begin
			open_line = 1'b1;
			if (c == lsf_pkg::ZERO_BYTE) begin
				cut_seen = 1'b1;
			end else if (!cut_seen) begin
				scan_text_byte(c);
			end
			if (c == lsf_pkg::NEWLINE_BYTE) begin
				close_line();
			end
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_byte(data_byte, end_of_input);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_text.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
					next_text = pending_text.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_text.value;
					end_of_input <= next_text.stop;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_lines.size() == 0) begin
					errors++;
					$display("%0t: unexpected line result, expected none, actual sel %0d num %0d any %0d",
						$time, line_selected, line_number, any_selected);
				end else begin
					want = due_lines.pop_front();
					if (line_selected !== want.selected) begin
						errors++;
						$display("%0t: line_selected expected %0d actual %0d",
							$time, want.selected, line_selected);
					end
					if (line_number !== want.number) begin
						errors++;
						$display("%0t: line_number expected %0d actual %0d",
							$time, want.number, line_number);
					end
					if (any_selected !== want.any) begin
						errors++;
						$display("%0t: any_selected expected %0d actual %0d (line %0d)",
							$time, want.any, any_selected, want.number);
					end
					lines_checked++;
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && lines_checked >= HOLD_AT_LINE &&
				pending_text.size() > PHASE_BYTES / 2) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 38);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("line_substring_filter_top_tb: done, errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		text_item_t t;
		t.value = b;
		t.stop = 1'b0;
		pending_text.push_back(t);
		bytes_queued++;
	endtask

	task automatic push_end();
		text_item_t t;
		t.value = 8'($urandom_range(0, 255));
		t.stop = 1'b1;
		pending_text.push_back(t);
		bytes_queued++;
	endtask

	task automatic push_chars(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	task automatic push_filler(input int n);
		for (int i = 0; i < n; i++) begin
			push_byte(8'($urandom_range(8'h20, 8'h7E)));
		end
	endtask

	// pattern bytes, with random case flips when folding is on
	task automatic push_pattern(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = pat_byte_at(i);
			if (cfg_fold && $urandom_range(0, 1) &&
				((b >= lsf_pkg::UPPER_A && b <= lsf_pkg::UPPER_Z) ||
				(b >= LOWER_A && b <= LOWER_Z))) begin
				b = b ^ lsf_pkg::CASE_OFFSET;
			end
			push_byte(b);
		end
	endtask

	task automatic queue_random_line();
		int plen;
		int n;
		plen = active_length();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				push_filler($urandom_range(0, 4));
				push_pattern(plen);
				push_filler($urandom_range(0, 4));
				push_byte(lsf_pkg::NEWLINE_BYTE);
			end
			5: begin
				// near miss: pattern minus its last byte
				push_filler($urandom_range(0, 3));
				push_pattern((plen > 0) ? plen - 1 : 0);
				push_filler($urandom_range(0, 3));
				push_byte(lsf_pkg::NEWLINE_BYTE);
			end
			6: begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					push_byte(8'($urandom_range(0, 255)));
				end
				push_byte(lsf_pkg::NEWLINE_BYTE);
			end
			7: begin
				push_filler($urandom_range(0, 3));
				push_byte(lsf_pkg::ZERO_BYTE);
				push_pattern(plen);
				push_byte(lsf_pkg::NEWLINE_BYTE);
			end
			8: begin
				push_filler($urandom_range(0, 3));
				push_pattern(plen);
				push_end();
				if ($urandom_range(0, 1)) begin
					push_end();
				end
			end
			default: begin
				push_filler($urandom_range(0, 3));
				push_byte(lsf_pkg::NEWLINE_BYTE);
			end
		endcase
	endtask

	task automatic random_phase();
		int target;
		target = bytes_queued + PHASE_BYTES;
		while (bytes_queued < target) begin
			queue_random_line();
		end
		// sometimes leave a line open across the next register change
		if ($urandom_range(0, 2) == 0) begin
			push_filler($urandom_range(1, 3));
		end
	endtask

	task automatic write_reg(input logic [lsf_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			lsf_pkg::REG_PATTERN_LO:     cfg_pat_lo = val;
			lsf_pkg::REG_PATTERN_HI:     cfg_pat_hi = val;
			lsf_pkg::REG_PATTERN_LENGTH: cfg_pat_len = val[4:0];
			lsf_pkg::REG_FOLD_CASE:      cfg_fold = val[0];
			lsf_pkg::REG_INVERT_MATCH:   cfg_invert = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
		input logic [4:0] len, input logic fold, input logic inv);
		write_reg(lsf_pkg::REG_PATTERN_LO, lo);
		write_reg(lsf_pkg::REG_PATTERN_HI, hi);
		write_reg(lsf_pkg::REG_PATTERN_LENGTH, {59'd0, len});
		write_reg(lsf_pkg::REG_FOLD_CASE, {63'd0, fold});
		write_reg(lsf_pkg::REG_INVERT_MATCH, {63'd0, inv});
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic drain_all();
		int waited;
		waited = 0;
		while ((bytes_taken != bytes_queued || due_lines.size() > 0) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_lines.size() > 0) begin
			errors += due_lines.size();
			$display("%0t: %0d line results never arrived, next expected line %0d",
				$time, due_lines.size(), due_lines[0].number);
			due_lines.delete();
		end
	endtask

	function automatic logic [63:0] printable_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			w[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
		end
		return w;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// "aBc", folded
		apply_setting(64'h0000_0000_0063_4261, 64'd0, 5'd3, 1'b1, 1'b0);
		push_end();
		push_chars("q\n");
		push_chars("xAbC\n");
		push_chars("ab");
		push_byte(lsf_pkg::ZERO_BYTE);
		push_chars("c\n");
		push_chars("zab");
		push_end();
		push_end();
		push_chars("\n");
		push_byte(8'hFF);
		push_chars("ABC\n");
		drain_all();
		random_phase();
		drain_all();

		// empty pattern selects every line
		apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b0, 1'b0);
		random_phase();
		drain_all();

		// full length of all-ones bytes, inverted
		apply_setting('1, '1, 5'd16, 1'b0, 1'b1);
		random_phase();
		drain_all();

		// length above the register size clamps
		apply_setting(printable_word(), printable_word(), 5'd31, 1'b1, 1'b0);
		random_phase();
		drain_all();

		// zero byte inside the pattern shortens it
		apply_setting(64'h0000_0077_7A00_7978, 64'd0, 5'd8, 1'b0, 1'b0);
		random_phase();
		drain_all();

		// pattern ending in newline, no idling on either side
		calm = 1'b1;
		apply_setting(64'h0000_0000_000A_6B6F, 64'd0, 5'd3, 1'b1, 1'b1);
		random_phase();
		drain_all();
		calm = 1'b0;

		apply_setting({56'd0, 8'($urandom_range(1, 255))}, 64'd0, 5'd1,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		random_phase();
		drain_all();

		apply_setting(64'd0, 64'd0, 5'd0, 1'b0, 1'b1);
		random_phase();
		drain_all();

		repeat (3) begin
			apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			random_phase();
			drain_all();
		end

		$display("run covered %0d stream items, %0d line results, %0d register settings",
			bytes_taken, lines_checked, settings_used);
		$display("with random idling both ways, a %0d-cycle output hold-off and a gapless phase",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("line_substring_filter_top_tb: done, clean");
		end else begin
			$display("line_substring_filter_top_tb: done, errors");
		end
		$finish;
	end

endmodule
